### design/mbdf_pkg.sv
package mbdf_pkg;

  localparam int MaxShapes  = 32;
  localparam int IdxW       = $clog2(MaxShapes);
  localparam int CntW       = 6;
  localparam int CoordW     = 18;
  localparam int MagW       = 24;
  localparam int DensW      = 32;
  localparam int DiffW      = CoordW + 1;
  localparam int SqW        = 2 * DiffW;
  localparam int D2W        = SqW + 2;
  localparam int NumW       = MagW + 32;
  localparam int SumW       = NumW + IdxW + 1;
  localparam int EpsQ32     = 429;
  localparam int OneQ16     = 65536;
  localparam int EntryW     = 3 * CoordW + MagW;
  localparam int QdivCntW   = $clog2(NumW + 1);
  localparam int CdivCntW   = $clog2(SumW + 1);

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic latch_point;
    logic clear_sum;
    logic rd_en;
    logic load_diff;
    logic load_sq;
    logic load_d2;
    logic term_start;
    logic term_add;
    logic mean_start;
    logic load_out;
  } mbdf_cmd_t;

  // status back to the controller
  typedef struct packed {
    logic term_done;
    logic mean_done;
  } mbdf_sts_t;

endpackage

### design/mbdf_ram.sv
module mbdf_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/mbdf_div.sv
module mbdf_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [mbdf_pkg::NumW-1:0]    numer,
  input  logic [mbdf_pkg::D2W-1:0]     denom,
  output logic                         done,
  output logic [mbdf_pkg::NumW-1:0]    quot
);

  logic [mbdf_pkg::NumW-1:0]     rem_q;
  logic [mbdf_pkg::NumW-1:0]     num_sh;
  logic [mbdf_pkg::D2W-1:0]      den;
  logic [mbdf_pkg::QdivCntW-1:0] cnt;
  logic                          busy;
  logic [mbdf_pkg::NumW:0]       trial;
  logic [mbdf_pkg::NumW:0]       rem_sh;

  // restoring division, one quotient bit a cycle
  always_comb begin
    rem_sh = {rem_q, num_sh[mbdf_pkg::NumW-1]};
    trial  = rem_sh - {{(mbdf_pkg::NumW + 1 - mbdf_pkg::D2W){1'b0}}, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= mbdf_pkg::QdivCntW'(mbdf_pkg::NumW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == mbdf_pkg::QdivCntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_q  <= '0;
      num_sh <= numer;
      den    <= denom;
      quot   <= '0;
    end else if (busy) begin
      num_sh <= {num_sh[mbdf_pkg::NumW-2:0], 1'b0};
      if (!trial[mbdf_pkg::NumW]) begin
        rem_q <= trial[mbdf_pkg::NumW-1:0];
        quot  <= {quot[mbdf_pkg::NumW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[mbdf_pkg::NumW-1:0];
        quot  <= {quot[mbdf_pkg::NumW-2:0], 1'b0};
      end
    end
  end

endmodule

### design/mbdf_cdiv.sv
module mbdf_cdiv (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [mbdf_pkg::SumW-1:0]    numer,
  input  logic [mbdf_pkg::CntW-1:0]    denom,
  output logic                         done,
  output logic [mbdf_pkg::SumW-1:0]    quot
);

  logic [mbdf_pkg::CntW-1:0]     rem_q;
  logic [mbdf_pkg::SumW-1:0]     num_sh;
  logic [mbdf_pkg::CntW-1:0]     den;
  logic [mbdf_pkg::CdivCntW-1:0] cnt;
  logic                          busy;
  logic [mbdf_pkg::CntW:0]       rem_sh;
  logic [mbdf_pkg::CntW:0]       trial;

  // restoring division of the sum by the shape count
  always_comb begin
    rem_sh = {rem_q, num_sh[mbdf_pkg::SumW-1]};
    trial  = rem_sh - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= mbdf_pkg::CdivCntW'(mbdf_pkg::SumW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == mbdf_pkg::CdivCntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_q  <= '0;
      num_sh <= numer;
      den    <= denom;
      quot   <= '0;
    end else if (busy) begin
      num_sh <= {num_sh[mbdf_pkg::SumW-2:0], 1'b0};
      if (!trial[mbdf_pkg::CntW]) begin
        rem_q <= trial[mbdf_pkg::CntW-1:0];
        quot  <= {quot[mbdf_pkg::SumW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[mbdf_pkg::CntW-1:0];
        quot  <= {quot[mbdf_pkg::SumW-2:0], 1'b0};
      end
    end
  end

endmodule

### design/mbdf_datapath.sv
module mbdf_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  mbdf_pkg::mbdf_cmd_t               cmd,
  output mbdf_pkg::mbdf_sts_t               sts,
  input  logic [mbdf_pkg::IdxW-1:0]         rd_idx,
  input  logic [mbdf_pkg::CntW-1:0]         count,
  input  logic                              wr_en,
  input  logic [mbdf_pkg::IdxW-1:0]         wr_idx,
  input  logic signed [mbdf_pkg::CoordW-1:0] in_x,
  input  logic signed [mbdf_pkg::CoordW-1:0] in_y,
  input  logic signed [mbdf_pkg::CoordW-1:0] in_z,
  input  logic [mbdf_pkg::MagW-1:0]         in_mag,
  output logic signed [mbdf_pkg::DensW-1:0] dens
);

  logic [mbdf_pkg::EntryW-1:0] rd_word;
  logic signed [mbdf_pkg::CoordW-1:0] px, py, pz;
  logic signed [mbdf_pkg::CoordW-1:0] sx, sy, sz;
  logic [mbdf_pkg::MagW-1:0] smag, mag_q;
  logic signed [mbdf_pkg::DiffW-1:0] dx, dy, dz;
  logic [mbdf_pkg::SqW-1:0] qx, qy, qz;
  logic [mbdf_pkg::D2W-1:0] d2;
  logic [mbdf_pkg::SumW-1:0] sum;
  logic [mbdf_pkg::NumW-1:0] term;
  logic [mbdf_pkg::SumW-1:0] mean;
  logic signed [mbdf_pkg::SumW+1:0] total;
  logic term_done, mean_done;

  // shape table, one entry a word
  mbdf_ram #(.Width(mbdf_pkg::EntryW), .Depth(mbdf_pkg::MaxShapes)) u_table (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_idx),
    .wdata({in_x, in_y, in_z, in_mag}),
    .re   (cmd.rd_en),
    .raddr(rd_idx),
    .rdata(rd_word)
  );

  assign {sx, sy, sz, smag} = rd_word;

  // point latch and distance pipeline
  always_ff @(posedge clk) begin
    if (cmd.latch_point) begin
      px <= in_x;
      py <= in_y;
      pz <= in_z;
    end
    if (cmd.load_diff) begin
      dx    <= mbdf_pkg::DiffW'(px) - mbdf_pkg::DiffW'(sx);
      dy    <= mbdf_pkg::DiffW'(py) - mbdf_pkg::DiffW'(sy);
      dz    <= mbdf_pkg::DiffW'(pz) - mbdf_pkg::DiffW'(sz);
      mag_q <= smag;
    end
    if (cmd.load_sq) begin
      qx <= mbdf_pkg::SqW'(dx * dx);
      qy <= mbdf_pkg::SqW'(dy * dy);
      qz <= mbdf_pkg::SqW'(dz * dz);
    end
    if (cmd.load_d2) begin
      d2 <= mbdf_pkg::D2W'(qx) + mbdf_pkg::D2W'(qy) + mbdf_pkg::D2W'(qz)
          + mbdf_pkg::D2W'(mbdf_pkg::EpsQ32);
    end
  end

  mbdf_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.term_start),
    .numer({mag_q, 32'd0}),
    .denom(d2),
    .done (term_done),
    .quot (term)
  );

  // running sum of terms
  always_ff @(posedge clk) begin
    if (cmd.clear_sum) begin
      sum <= '0;
    end else if (cmd.term_add) begin
      sum <= sum + mbdf_pkg::SumW'(term);
    end
  end

  mbdf_cdiv u_cdiv (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.mean_start),
    .numer(sum),
    .denom(count),
    .done (mean_done),
    .quot (mean)
  );

  // status to the controller
  always_comb begin
    sts.term_done = term_done;
    sts.mean_done = mean_done;
  end

  // base minus the point's z, plus mean, saturated
  always_comb begin
    total = $signed({2'b00, mean}) + (mbdf_pkg::SumW+2)'(mbdf_pkg::OneQ16)
          - (mbdf_pkg::SumW+2)'(pz);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (total > (mbdf_pkg::SumW+2)'(32'sh7FFF_FFFF)) begin
        dens <= 32'sh7FFF_FFFF;
      end else if (total < -(mbdf_pkg::SumW+2)'(33'sh0_8000_0000)) begin
        dens <= 32'sh8000_0000;
      end else begin
        dens <= total[mbdf_pkg::DensW-1:0];
      end
    end
  end

endmodule

### design/mbdf_ctrl.sv
module mbdf_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_acc,
  input  logic                      in_mode,
  input  logic [mbdf_pkg::CntW-1:0] count,
  input  mbdf_pkg::mbdf_sts_t       sts,
  output mbdf_pkg::mbdf_cmd_t       cmd,
  output logic [mbdf_pkg::IdxW-1:0] rd_idx,
  output logic                      busy,
  output logic                      out_valid,
  input  logic                      out_stall
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_READ = 8'b0000_0010,
    S_DIFF = 8'b0000_0100,
    S_SQ   = 8'b0000_1000,
    S_D2   = 8'b0001_0000,
    S_DIV  = 8'b0010_0000,
    S_MEAN = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic [mbdf_pkg::CntW-1:0] idx;
  logic last;
  logic div_go, mean_go;

  assign rd_idx = idx[mbdf_pkg::IdxW-1:0];
  assign last   = (idx + 1'b1) == count;
  assign busy   = (state != S_IDLE) || out_valid;

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.term_start = div_go;
    cmd.mean_start = mean_go;
    unique case (state)
      S_IDLE: begin
        if (in_acc && in_mode == mbdf_pkg::MODE_EVAL) begin
          cmd.latch_point = 1'b1;
          cmd.clear_sum   = 1'b1;
          state_next      = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd.load_diff = 1'b1;
        state_next    = S_SQ;
      end
      S_SQ: begin
        cmd.load_sq = 1'b1;
        state_next  = S_D2;
      end
      S_D2: begin
        cmd.load_d2 = 1'b1;
        state_next  = S_DIV;
      end
      S_DIV: begin
        if (sts.term_done) begin
          cmd.term_add = 1'b1;
          if (last) begin
            state_next = S_MEAN;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_MEAN: begin
        if (sts.mean_done) begin
          cmd.load_out = 1'b1;
          state_next   = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // pulse to start the per-shape division and the final mean
  always_ff @(posedge clk) begin
    if (rst) begin
      div_go  <= 1'b0;
      mean_go <= 1'b0;
    end else begin
      div_go  <= (state == S_D2);
      mean_go <= (state == S_DIV) && sts.term_done && last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) begin
        idx <= '0;
      end else if (state == S_DIV && sts.term_done) begin
        idx <= idx + 1'b1;
      end
      // output word held until taken
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### design/metaball_density_field_core.sv
// Metaball density field evaluator.
// Input channel (in_valid / in_stall) carries one word per item. A word with
// mode 0 writes shape_index of the shape table with the position and
// shape_strength; it gives no output. A word with mode 1 evaluates density at
// (coord_x, coord_y, coord_z) and gives one output word on out_valid /
// out_stall.
// The config channel (cfg_valid / cfg_ready) writes shape_count; 0 acts as 1,
// values over 32 act as 32. Write it only while idle.
// Each shape of an evaluate word goes through the read, diff, square and d2
// states and then the bit-per-cycle divider; after the last shape the mean
// comes from its own divider. Loads can go back to back. One evaluate is in
// flight at a time; in_stall stays high from accept until its output word is
// taken, and the next word can be taken in the cycle after that.
// Synchronous reset empties the pipeline and sets shape_count to 20; the shape
// table is not cleared and must be loaded before use.
// When the receiver stalls, density holds and out_valid stays high.
module metaball_density_field_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              mode,
  input  logic [mbdf_pkg::IdxW-1:0]         shape_index,
  input  logic signed [mbdf_pkg::CoordW-1:0] coord_x,
  input  logic signed [mbdf_pkg::CoordW-1:0] coord_y,
  input  logic signed [mbdf_pkg::CoordW-1:0] coord_z,
  input  logic [mbdf_pkg::MagW-1:0]         shape_strength,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mbdf_pkg::CntW-1:0]         cfg_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [mbdf_pkg::DensW-1:0] density
);

  mbdf_pkg::mbdf_cmd_t cmd;
  mbdf_pkg::mbdf_sts_t sts;
  logic [mbdf_pkg::IdxW-1:0] rd_idx;
  logic [mbdf_pkg::CntW-1:0] shape_count, count_eff;
  logic busy, in_acc;

  assign in_stall  = busy;
  assign in_acc    = in_valid && !busy;
  assign cfg_ready = 1'b1;

  // register write and clamping of the count
  always_ff @(posedge clk) begin
    if (rst) begin
      shape_count <= mbdf_pkg::CntW'(20);
    end else if (cfg_valid && cfg_ready) begin
      shape_count <= cfg_data;
    end
  end

  always_comb begin
    if (shape_count == '0) begin
      count_eff = mbdf_pkg::CntW'(1);
    end else if (shape_count > mbdf_pkg::CntW'(mbdf_pkg::MaxShapes)) begin
      count_eff = mbdf_pkg::CntW'(mbdf_pkg::MaxShapes);
    end else begin
      count_eff = shape_count;
    end
  end

  mbdf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_acc   (in_acc),
    .in_mode  (mode),
    .count    (count_eff),
    .sts      (sts),
    .cmd      (cmd),
    .rd_idx   (rd_idx),
    .busy     (busy),
    .out_valid(out_valid),
    .out_stall(out_stall)
  );

  mbdf_datapath u_dp (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .sts   (sts),
    .rd_idx(rd_idx),
    .count (count_eff),
    .wr_en (in_acc && mode == mbdf_pkg::MODE_LOAD),
    .wr_idx(shape_index),
    .in_x  (coord_x),
    .in_y  (coord_y),
    .in_z  (coord_z),
    .in_mag(shape_strength),
    .dens  (density)
  );

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int CycleLimit = 8000000;
  localparam int HoldCycles = 4000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic mode;
  logic [mbdf_pkg::IdxW-1:0] shape_index;
  logic signed [mbdf_pkg::CoordW-1:0] coord_x;
  logic signed [mbdf_pkg::CoordW-1:0] coord_y;
  logic signed [mbdf_pkg::CoordW-1:0] coord_z;
  logic [mbdf_pkg::MagW-1:0] shape_strength;
  logic cfg_valid;
  logic cfg_ready;
  logic [mbdf_pkg::CntW-1:0] cfg_data;
  logic out_valid;
  logic out_stall;
  logic signed [mbdf_pkg::DensW-1:0] density;

  // shadow of the shape table and the count register
  logic signed [mbdf_pkg::CoordW-1:0] tab_x [mbdf_pkg::MaxShapes];
  logic signed [mbdf_pkg::CoordW-1:0] tab_y [mbdf_pkg::MaxShapes];
  logic signed [mbdf_pkg::CoordW-1:0] tab_z [mbdf_pkg::MaxShapes];
  logic [mbdf_pkg::MagW-1:0] tab_mag [mbdf_pkg::MaxShapes];
  logic [mbdf_pkg::CntW-1:0] shape_cnt;

  logic signed [mbdf_pkg::DensW-1:0] density_q [$];
  int errors;
  int loads_sent;
  int evals_sent;
  int words_checked;
  int saturated_seen;
  int cycles;
  bit quiet;
  bit press_req;
  int hold_left;
  int out_gap;

  metaball_density_field_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .shape_index   (shape_index),
    .coord_x       (coord_x),
    .coord_y       (coord_y),
    .coord_z       (coord_z),
    .shape_strength(shape_strength),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .density       (density)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles", cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic report(input string what, input logic [mbdf_pkg::DensW-1:0] got,
                        input logic [mbdf_pkg::DensW-1:0] want);
    $display("mismatch %s: got %h, expected %h", what, got, want);
    errors++;
  endtask

  // expected density of one point from the shadow table
  function automatic logic signed [mbdf_pkg::DensW-1:0] field_density(
      input logic signed [mbdf_pkg::CoordW-1:0] px,
      input logic signed [mbdf_pkg::CoordW-1:0] py,
      input logic signed [mbdf_pkg::CoordW-1:0] pz);
    int n;
    longint dx, dy, dz;
    longint unsigned d2, num, acc;
    longint total;
    n = shape_cnt;
    if (n < 1) n = 1;
    if (n > mbdf_pkg::MaxShapes) n = mbdf_pkg::MaxShapes;
    acc = 0;
    for (int i = 0; i < n; i++) begin
      dx = longint'(px) - longint'(tab_x[i]);
      dy = longint'(py) - longint'(tab_y[i]);
      dz = longint'(pz) - longint'(tab_z[i]);
      d2 = longint'(dx * dx + dy * dy + dz * dz + mbdf_pkg::EpsQ32);
      num = longint'(tab_mag[i]) << 32;
      acc += num / d2;
    end
    total = longint'(acc / longint'(n)) + mbdf_pkg::OneQ16 - longint'(pz);
    if (total > 64'sd2147483647) total = 64'sd2147483647;
    if (total < -64'sd2147483648) total = -64'sd2147483648;
    return total[mbdf_pkg::DensW-1:0];
  endfunction

  // send one word, update the shadow state when it is taken
  task automatic send_word(input logic m, input logic [mbdf_pkg::IdxW-1:0] idx,
                           input logic signed [mbdf_pkg::CoordW-1:0] x,
                           input logic signed [mbdf_pkg::CoordW-1:0] y,
                           input logic signed [mbdf_pkg::CoordW-1:0] z,
                           input logic [mbdf_pkg::MagW-1:0] mag);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    mode <= m;
    shape_index <= idx;
    coord_x <= x;
    coord_y <= y;
    coord_z <= z;
    shape_strength <= mag;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (m == mbdf_pkg::MODE_LOAD) begin
      tab_x[idx] = x;
      tab_y[idx] = y;
      tab_z[idx] = z;
      tab_mag[idx] = mag;
      loads_sent++;
    end else begin
      density_q.push_back(field_density(x, y, z));
      evals_sent++;
    end
  endtask

  task automatic send_eval(input logic signed [mbdf_pkg::CoordW-1:0] x,
                           input logic signed [mbdf_pkg::CoordW-1:0] y,
                           input logic signed [mbdf_pkg::CoordW-1:0] z);
    send_word(mbdf_pkg::MODE_EVAL, mbdf_pkg::IdxW'($urandom), x, y, z,
              mbdf_pkg::MagW'($urandom));
  endtask

  // wait until every density word has come back and the block has settled
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (density_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_count(input logic [mbdf_pkg::CntW-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    shape_cnt = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver: random stall per word, plus a long hold on request
  initial begin
    out_stall = 1'b1;
    hold_left = 0;
    out_gap = 0;
    forever begin
      @(negedge clk);
      if (press_req) begin
        press_req = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (out_gap > 0 && !quiet) begin
        out_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // check each density word against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (density_q.size() == 0) begin
        report("unexpected word", density, '0);
      end else begin
        if (density !== density_q[0]) report("density", density, density_q[0]);
        if (density_q[0] == 32'sh7fffffff) saturated_seen++;
        void'(density_q.pop_front());
        words_checked++;
      end
      out_gap = $urandom_range(0, 8);
    end
  end

  function automatic logic signed [mbdf_pkg::CoordW-1:0] rand_coord();
    return mbdf_pkg::CoordW'($urandom);
  endfunction

  // point near a loaded shape, so some terms get large
  function automatic logic signed [mbdf_pkg::CoordW-1:0] near(
      input logic signed [mbdf_pkg::CoordW-1:0] c);
    return c + mbdf_pkg::CoordW'($urandom_range(0, 64)) - mbdf_pkg::CoordW'(32);
  endfunction

  // fill the whole table, extremes included, so no entry is read unwritten
  task automatic test_table_fill();
    send_word(mbdf_pkg::MODE_LOAD, 5'd0, 18'sh20000, 18'sh20000, 18'sh20000,
              24'hffffff);
    send_word(mbdf_pkg::MODE_LOAD, 5'd1, 18'sh1ffff, 18'sh1ffff, 18'sh1ffff,
              24'h000000);
    send_word(mbdf_pkg::MODE_LOAD, 5'd2, 18'sh00000, 18'sh00000, 18'sh00000,
              24'h010000);
    send_word(mbdf_pkg::MODE_LOAD, 5'd31, 18'sh3ffff, 18'sh00001, 18'sh20001,
              24'h800000);
    for (int i = 3; i < mbdf_pkg::MaxShapes - 1; i++)
      send_word(mbdf_pkg::MODE_LOAD, mbdf_pkg::IdxW'(i), rand_coord(), rand_coord(),
                rand_coord(), mbdf_pkg::MagW'($urandom));
  endtask

  // special points under the reset count
  task automatic test_directed_points();
    send_eval(18'sh20000, 18'sh20000, 18'sh20000);  // on top of shape 0: saturates
    send_eval(18'sh1ffff, 18'sh1ffff, 18'sh1ffff);  // zero-magnitude shape, z max
    send_eval(18'sh00000, 18'sh00000, 18'sh00000);  // on the unit shape
    send_eval(18'sh1ffff, 18'sh20000, 18'sh20000);  // far corner
    send_eval(18'sh00005, 18'sh3fffb, 18'sh00100);
  endtask

  // count register extremes, including values that get clamped
  task automatic test_count_settings();
    logic [mbdf_pkg::CntW-1:0] counts [5] = '{6'd0, 6'd1, 6'd32, 6'd33, 6'd63};
    foreach (counts[k]) begin
      write_count(counts[k]);
      send_eval(18'sh20000, 18'sh20000, 18'sh20000);
      send_eval(tab_x[31], tab_y[31], tab_z[31]);
      send_eval(rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  // mostly loads and evaluates with random content, some near shapes
  task automatic test_random_phase(input logic [mbdf_pkg::CntW-1:0] cnt,
                                   input int words, input bit no_gaps);
    int sel;
    int k;
    write_count(cnt);
    quiet = no_gaps;
    for (int i = 0; i < words; i++) begin
      sel = $urandom_range(0, 99);
      k = $urandom_range(0, mbdf_pkg::MaxShapes - 1);
      if (sel < 55)
        send_word(mbdf_pkg::MODE_LOAD, mbdf_pkg::IdxW'(k), rand_coord(), rand_coord(),
                  rand_coord(),
                  ($urandom_range(0, 3) == 0) ? mbdf_pkg::MagW'($urandom_range(0, 255))
                                              : mbdf_pkg::MagW'($urandom));
      else if (sel < 75)
        send_eval(near(tab_x[k]), near(tab_y[k]), near(tab_z[k]));
      else
        send_eval(rand_coord(), rand_coord(), rand_coord());
    end
    quiet = 1'b0;
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_backpressure();
    write_count(6'd4);
    press_req = 1'b1;
    send_eval(rand_coord(), rand_coord(), rand_coord());
    for (int i = 0; i < 6; i++)
      send_word(mbdf_pkg::MODE_LOAD, mbdf_pkg::IdxW'(i), rand_coord(), rand_coord(),
                rand_coord(), mbdf_pkg::MagW'($urandom));
    send_eval(tab_x[2], tab_y[2], tab_z[2]);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    mode = mbdf_pkg::MODE_LOAD;
    shape_index = '0;
    coord_x = '0;
    coord_y = '0;
    coord_z = '0;
    shape_strength = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    errors = 0;
    loads_sent = 0;
    evals_sent = 0;
    words_checked = 0;
    saturated_seen = 0;
    quiet = 1'b0;
    press_req = 1'b0;
    shape_cnt = 6'd20;
    foreach (tab_mag[i]) begin
      tab_x[i] = '0;
      tab_y[i] = '0;
      tab_z[i] = '0;
      tab_mag[i] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_table_fill();
    test_directed_points();
    test_count_settings();
    test_backpressure();
    test_random_phase(6'd1, 200, 1'b0);
    test_random_phase(6'd0, 80, 1'b1);
    test_random_phase(6'd7, 200, 1'b0);
    test_random_phase(6'd20, 100, 1'b0);
    test_random_phase(6'd63, 60, 1'b0);
    test_random_phase(6'd32, 60, 1'b1);

    wait_idle();
    repeat (100) @(posedge clk);
    $display("covered %0d table loads and %0d point evaluations, %0d saturated",
             loads_sent, evals_sent, saturated_seen);
    $display("shape counts 0..63 incl. clamped values, long output hold, %0d checked",
             words_checked);
    if (errors == 0 && density_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d errors, %0d words missing", errors, density_q.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### metaball_density_field_core.f
design/mbdf_pkg.sv
design/mbdf_ram.sv
design/mbdf_div.sv
design/mbdf_cdiv.sv
design/mbdf_datapath.sv
design/mbdf_ctrl.sv
design/metaball_density_field_core.sv
sim/testbench.sv
